>>> design/lcdws_pkg.sv
package lcdws_pkg;

    // request kinds
    localparam logic [2:0] ACT_INIT  = 3'd0;
    localparam logic [2:0] ACT_CMD   = 3'd1;
    localparam logic [2:0] ACT_RAW   = 3'd2;
    localparam logic [2:0] ACT_TEXT  = 3'd3;
    localparam logic [2:0] ACT_GOTO  = 3'd4;
    localparam logic [2:0] ACT_GLYPH = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BUS_MODE  = 3'd0;
    localparam logic [2:0] CFG_COLUMNS   = 3'd1;
    localparam logic [2:0] CFG_FOUR_ROWS = 3'd2;
    localparam logic [2:0] CFG_THIRD_CMD = 3'd3;
    localparam logic [2:0] CFG_FOURTH_CMD = 3'd4;

    // display commands
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME4   = 8'h02;
    localparam logic [7:0] CMD_FUNC8   = 8'h38;
    localparam logic [7:0] CMD_FUNC4   = 8'h28;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_LINE1   = 8'h80;
    localparam logic [7:0] CMD_LINE2   = 8'hC0;
    localparam logic [7:0] CMD_DISP_ON = 8'h0F;
    localparam logic [1:0] CMD_CGRAM_HI = 2'b01;

    localparam logic [5:0] COLS_MAX = 6'd40;

    // longest byte list of one request (init on the nibble bus)
    localparam int MAX_BYTES = 6;
    localparam int BYTE_IDX_W = $clog2(MAX_BYTES);
    localparam int BYTE_CNT_W = $clog2(MAX_BYTES + 1);

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       text_start;
        logic [7:0] cursor_row;
        logic [7:0] cursor_col;
        logic [2:0] glyph_slot;
    } req_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus_value;
        logic       last;
    } xfer_t;

    // one classified request: bytes to send, first one may be a data byte
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic                      rs_first;
        logic [BYTE_CNT_W-1:0]     nbytes;
        logic                      eight_bit;
    } job_t;

endpackage

>>> design/char_lcd_write_sequencer_unit.sv
// accepted request: job registered in the queue, then first transfer in out_reg
// throughput: one request per cycle while the job queue has room; the back end
// sends one bus transfer per cycle while a job waits and its output is popped,
// so a request costs 0 to 12 transfers there (bytes times two on the four-bit
// bus, the twelve of init being the longest); reset: configuration returns to
// its defaults, character count and queue are cleared, the output marked empty
module char_lcd_write_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             push,
    output logic             full,
    input  lcdws_pkg::req_t  request,
    output logic             empty,
    input  logic             pop,
    output lcdws_pkg::xfer_t transfer
);
    import lcdws_pkg::*;

    logic accept;
    logic job_push;
    job_t job;
    job_t head;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    lcdws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .request  (request),
        .job_push (job_push),
        .job      (job)
    );

    lcdws_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .push_job(job),
        .pop     (head_pop),
        .head    (head),
        .empty   (head_empty),
        .full    (full)
    );

    lcdws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_empty(head_empty),
        .head_pop  (head_pop),
        .pop       (pop),
        .empty     (empty),
        .transfer  (transfer)
    );

endmodule

>>> design/lcdws_front.sv
module lcdws_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  lcdws_pkg::req_t   request,
    output logic              job_push,
    output lcdws_pkg::job_t   job
);
    import lcdws_pkg::*;

    logic       bus_mode_reg;
    logic [5:0] columns_reg;
    logic       four_rows_reg;
    logic [7:0] third_cmd_reg;
    logic [7:0] fourth_cmd_reg;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    logic [5:0] cols;
    logic [8:0] cols9;
    logic [8:0] n_inc;
    logic [8:0] n_after;
    logic [8:0] screen_cnt;
    logic       wrap_row1;
    logic       wrap_full;
    logic       row_ok;
    logic [7:0] row_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg   <= 1'b0;
            columns_reg    <= 6'd16;
            four_rows_reg  <= 1'b0;
            third_cmd_reg  <= 8'd148;
            fourth_cmd_reg <= 8'd212;
            count_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BUS_MODE:   bus_mode_reg   <= cfg_data[0];
                    CFG_COLUMNS:    columns_reg    <= cfg_data[5:0];
                    CFG_FOUR_ROWS:  four_rows_reg  <= cfg_data[0];
                    CFG_THIRD_CMD:  third_cmd_reg  <= cfg_data;
                    CFG_FOURTH_CMD: fourth_cmd_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                count_reg <= count_next;
        end
    end

    always_comb
    begin
        // clamp columns into 1..40
        if (columns_reg == 6'd0)
            cols = 6'd1;
        else if (columns_reg > COLS_MAX)
            cols = COLS_MAX;
        else
            cols = columns_reg;
        cols9 = {3'b000, cols};
        screen_cnt = four_rows_reg ? (cols9 << 2) : (cols9 << 1);

        n_inc = request.text_start ? 9'd1 : ({1'b0, count_reg} + 9'd1);
        wrap_row1 = (n_inc == cols9);
        wrap_full = !wrap_row1 && (n_inc == screen_cnt);
        n_after = wrap_full ? 9'd0 : n_inc;

        // goto row check and line base
        row_ok = 1'b1;
        row_base = CMD_LINE1;
        priority if (request.cursor_row == 8'd0)
            row_base = CMD_LINE1;
        else if (request.cursor_row == 8'd1)
            row_base = CMD_LINE2;
        else if (four_rows_reg && request.cursor_row == 8'd2)
            row_base = third_cmd_reg;
        else if (four_rows_reg && request.cursor_row == 8'd3)
            row_base = fourth_cmd_reg;
        else
            row_ok = 1'b0;

        job = '0;
        job.eight_bit = bus_mode_reg;
        count_next = count_reg;

        unique case (request.action)
            ACT_INIT:
            begin
                job.bytes[0] = CMD_CLEAR;
                if (bus_mode_reg)
                begin
                    job.bytes[1] = CMD_FUNC8;
                    job.bytes[2] = CMD_ENTRY;
                    job.bytes[3] = CMD_LINE1;
                    job.bytes[4] = CMD_DISP_ON;
                    job.nbytes   = BYTE_CNT_W'(5);
                end
                else
                begin
                    job.bytes[1] = CMD_HOME4;
                    job.bytes[2] = CMD_FUNC4;
                    job.bytes[3] = CMD_ENTRY;
                    job.bytes[4] = CMD_LINE1;
                    job.bytes[5] = CMD_DISP_ON;
                    job.nbytes   = BYTE_CNT_W'(6);
                end
            end
            ACT_CMD:
            begin
                job.bytes[0] = request.data_byte;
                job.nbytes   = BYTE_CNT_W'(1);
            end
            ACT_RAW:
            begin
                job.bytes[0] = request.data_byte;
                job.rs_first = 1'b1;
                job.nbytes   = BYTE_CNT_W'(1);
            end
            ACT_TEXT:
            begin
                job.bytes[0] = request.data_byte;
                job.rs_first = 1'b1;
                job.nbytes   = BYTE_CNT_W'(1);
                // the four cases below exclude each other for columns >= 1
                if (wrap_row1)
                begin
                    job.bytes[1] = CMD_LINE2;
                    job.nbytes   = BYTE_CNT_W'(2);
                end
                else if (wrap_full)
                begin
                    job.bytes[1] = CMD_CLEAR;
                    job.bytes[2] = CMD_LINE1;
                    job.nbytes   = BYTE_CNT_W'(3);
                end
                else if (four_rows_reg && n_after == (cols9 << 1))
                begin
                    job.bytes[1] = third_cmd_reg;
                    job.nbytes   = BYTE_CNT_W'(2);
                end
                else if (four_rows_reg && n_after == (cols9 + (cols9 << 1)))
                begin
                    job.bytes[1] = fourth_cmd_reg;
                    job.nbytes   = BYTE_CNT_W'(2);
                end
                count_next = n_after[7:0];
            end
            ACT_GOTO:
            begin
                if (row_ok && request.cursor_col < {2'b00, cols})
                begin
                    job.bytes[0] = row_base + request.cursor_col;
                    job.nbytes   = BYTE_CNT_W'(1);
                end
            end
            ACT_GLYPH:
            begin
                job.bytes[0] = {CMD_CGRAM_HI, request.glyph_slot, 3'b000};
                job.nbytes   = BYTE_CNT_W'(1);
            end
            default: ;
        endcase

        // requests that send nothing never reach the queue
        job_push = accept && (job.nbytes != '0);
    end

endmodule

>>> design/lcdws_queue.sv
module lcdws_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcdws_pkg::job_t push_job,
    input  logic            pop,
    output lcdws_pkg::job_t head,
    output logic            empty,
    output logic            full
);
    import lcdws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        empty = (count_reg == '0);
        full  = (count_reg == CNT_W'(DEPTH));
        head  = slots_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> design/lcdws_back.sv
module lcdws_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lcdws_pkg::job_t  head,
    input  logic             head_empty,
    output logic             head_pop,
    input  logic             pop,
    output logic             empty,
    output lcdws_pkg::xfer_t transfer
);
    import lcdws_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg;
    logic [BYTE_IDX_W-1:0] idx_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    xfer_t                 out_reg;
    xfer_t                 out_next;

    logic [7:0] cur_byte;
    logic       go;
    logic       last_byte;
    logic       byte_done;

    always_comb
    begin
        cur_byte  = head.bytes[idx_reg];
        go        = !head_empty && (!out_valid_reg || pop);
        last_byte = (BYTE_CNT_W'(idx_reg) + 1'b1) == head.nbytes;
        // high nibble goes first on the four-bit bus
        byte_done = head.eight_bit || phase_reg;
        head_pop  = go && byte_done && last_byte;

        out_next.rs = head.rs_first && (idx_reg == '0);
        if (head.eight_bit)
            out_next.bus_value = cur_byte;
        else if (phase_reg)
            out_next.bus_value = {4'b0000, cur_byte[3:0]};
        else
            out_next.bus_value = {4'b0000, cur_byte[7:4]};
        out_next.last = byte_done && last_byte;

        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (go)
        begin
            if (head_pop)
            begin
                idx_next   = '0;
                phase_next = 1'b0;
            end
            else if (byte_done)
            begin
                idx_next   = idx_reg + 1'b1;
                phase_next = 1'b0;
            end
            else
                phase_next = 1'b1;
        end

        if (go)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        empty    = !out_valid_reg;
        transfer = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            out_reg <= out_next;
    end

endmodule
